FILE: hw/rtl/pfc_pkg.sv
package pfc_pkg;

  localparam int GRID_SIDE   = 6;
  localparam int NUM_SYMBOLS = GRID_SIDE * GRID_SIDE;
  localparam int SYM_W       = $clog2(NUM_SYMBOLS);
  localparam int COORD_W     = $clog2(GRID_SIDE);

  // Symbol index of 'X', used to pad a lone character at end of text.
  localparam logic [SYM_W-1:0] PAD_SYMBOL = SYM_W'(23);

  // Item kinds carried on the input tuser field.
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_TEXT   = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  typedef struct packed {
    logic latch_item;
    logic key_place;
    logic fill_start;
    logic fill_step;
    logic set_pending;
    logic save_cur;
    logic sel_addr2;
    logic cap1;
    logic cap2;
    logic load_out1;
    logic load_out2;
    logic clear_pending;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       sym_ok;
    logic       grid_ready;
    logic       pend_valid;
    logic       fill_last;
    logic       out_free;
  } status_t;

  // Returns {valid, symbol index}; letters of either case and digits are valid.
  function automatic logic [SYM_W:0] sym_of_ascii(input logic [7:0] ch);
    logic [7:0] diff;
    diff = 8'd0;
    if (ch >= 8'd65 && ch <= 8'd90) begin
      diff = ch - 8'd65;
      return {1'b1, diff[SYM_W-1:0]};
    end
    if (ch >= 8'd97 && ch <= 8'd122) begin
      diff = ch - 8'd97;
      return {1'b1, diff[SYM_W-1:0]};
    end
    if (ch >= 8'd48 && ch <= 8'd57) begin
      diff = ch - 8'd22;
      return {1'b1, diff[SYM_W-1:0]};
    end
    return '0;
  endfunction

  function automatic logic [7:0] ascii_of_sym(input logic [SYM_W-1:0] s);
    if (s < SYM_W'(26)) begin
      return 8'd65 + 8'(s);
    end
    return 8'd22 + 8'(s);
  endfunction

  function automatic logic [SYM_W-1:0] cell_index(input logic [COORD_W-1:0] row,
                                                  input logic [COORD_W-1:0] col);
    return SYM_W'(row) * SYM_W'(GRID_SIDE) + SYM_W'(col);
  endfunction

endpackage

FILE: hw/rtl/playfair_square_bigram_cipher.sv
// Channel   Direction  Signals                          Content
// s_*       in         tvalid tready tdata[7:0] tuser   tdata: ch; tuser: kind
// m_*       out        tvalid tready tdata[7:0] tlast   tdata: out_char; tlast: last
//
// One input transaction is taken at a time. A key character is handled at
// dispatch; a finish-key item walks the alphabet (all 36 symbols, one per cycle);
// a first text character takes a place lookup and is kept as pending; a
// pair-closing text character or end of text takes a place lookup, then two cell
// reads in turn (each table has a single read port), then two output loads that
// may wait on the output register. Reset (rst, synchronous) empties the square,
// drops any pending character and the output register. The output register lets
// a new transaction start while the second symbol of a pair waits for m_tready.
module playfair_square_bigram_cipher (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] ch
  input  logic [1:0] s_tuser,   // [1:0] kind
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast
);

  // The controller sequences each transaction; the datapath holds the square
  // (a cell table and a symbol placement table, both small RAMs), the key fill
  // counters, the pending character of an unfinished pair and the output
  // register.
  pfc_pkg::cmd_t    cmd;
  pfc_pkg::status_t status;

  pfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pfc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: hw/rtl/pfc_ram.sv
module pfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/pfc_dp.sv
module pfc_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       s_tdata,
  input  logic [1:0]       s_tuser,
  input  pfc_pkg::cmd_t    cmd,
  output pfc_pkg::status_t status,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast
);

  localparam int SW = pfc_pkg::SYM_W;
  localparam int CW = pfc_pkg::COORD_W;
  localparam int N  = pfc_pkg::NUM_SYMBOLS;

  logic [1:0]    kind_q;
  logic [SW-1:0] sym_q;
  logic          sym_ok_q;

  logic [N-1:0]  placed, placed_base, placed_next;
  logic [SW-1:0] key_count, count_base, count_next;
  logic [CW-1:0] key_row, row_base, row_next;
  logic [CW-1:0] key_col, col_base, col_next;
  logic          grid_ready;
  logic          clear;
  logic [SW-1:0] place_sym;
  logic          do_place;

  logic [SW-1:0] fill_idx;
  logic          pend_valid;
  logic [CW-1:0] pend_row, pend_col, cur_row;
  logic [SW-1:0] hold1, hold2;
  logic          out_valid, out_last;
  logic [7:0]    out_char;

  logic [SW-1:0]   place_raddr;
  logic [2*CW-1:0] place_rdata;
  logic [SW-1:0]   cell_raddr, cell_rdata;

  // A key character on a finished square starts a fresh key.
  always_comb begin
    clear       = cmd.key_place && grid_ready;
    placed_base = clear ? '0 : placed;
    count_base  = clear ? '0 : key_count;
    row_base    = clear ? '0 : key_row;
    col_base    = clear ? '0 : key_col;
    place_sym   = cmd.fill_step ? fill_idx : sym_q;
    do_place    = ((cmd.key_place && sym_ok_q) || cmd.fill_step) &&
                  !placed_base[place_sym] && (count_base < SW'(N));
    placed_next = placed_base;
    count_next  = count_base;
    row_next    = row_base;
    col_next    = col_base;
    if (do_place) begin
      placed_next[place_sym] = 1'b1;
      count_next = count_base + SW'(1);
      if (col_base == CW'(pfc_pkg::GRID_SIDE - 1)) begin
        col_next = '0;
        row_next = row_base + CW'(1);
      end else begin
        col_next = col_base + CW'(1);
      end
    end
  end

  assign place_raddr = (kind_q == pfc_pkg::KIND_END) ? pfc_pkg::PAD_SYMBOL : sym_q;
  assign cell_raddr  = cmd.sel_addr2 ? pfc_pkg::cell_index(cur_row, pend_col)
                                     : pfc_pkg::cell_index(pend_row, place_rdata[CW-1:0]);

  pfc_ram #(.WIDTH(2 * CW), .DEPTH(N)) u_place_ram (
    .clk   (clk),
    .we    (do_place),
    .waddr (place_sym),
    .wdata ({row_base, col_base}),
    .raddr (place_raddr),
    .rdata (place_rdata)
  );

  pfc_ram #(.WIDTH(SW), .DEPTH(N)) u_cell_ram (
    .clk   (clk),
    .we    (do_place),
    .waddr (count_base),
    .wdata (place_sym),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      placed     <= '0;
      key_count  <= '0;
      key_row    <= '0;
      key_col    <= '0;
      grid_ready <= 1'b0;
      pend_valid <= 1'b0;
      fill_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      placed    <= placed_next;
      key_count <= count_next;
      key_row   <= row_next;
      key_col   <= col_next;
      if (clear) begin
        grid_ready <= 1'b0;
      end else if (cmd.fill_step && status.fill_last) begin
        grid_ready <= 1'b1;
      end
      if (clear || cmd.clear_pending) begin
        pend_valid <= 1'b0;
      end else if (cmd.set_pending) begin
        pend_valid <= 1'b1;
      end
      if (cmd.fill_start) begin
        fill_idx <= '0;
      end else if (cmd.fill_step) begin
        fill_idx <= fill_idx + SW'(1);
      end
      if (cmd.load_out1 || cmd.load_out2) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      kind_q            <= s_tuser;
      {sym_ok_q, sym_q} <= pfc_pkg::sym_of_ascii(s_tdata);
    end
    if (cmd.set_pending) begin
      {pend_row, pend_col} <= place_rdata;
    end
    if (cmd.save_cur) begin
      cur_row <= place_rdata[2*CW-1:CW];
    end
    if (cmd.cap1) begin
      hold1 <= cell_rdata;
    end
    if (cmd.cap2) begin
      hold2 <= cell_rdata;
    end
    if (cmd.load_out1) begin
      out_char <= pfc_pkg::ascii_of_sym(hold1);
      out_last <= 1'b0;
    end else if (cmd.load_out2) begin
      out_char <= pfc_pkg::ascii_of_sym(hold2);
      out_last <= 1'b1;
    end
  end

  assign status.kind       = kind_q;
  assign status.sym_ok     = sym_ok_q;
  assign status.grid_ready = grid_ready;
  assign status.pend_valid = pend_valid;
  assign status.fill_last  = (fill_idx == SW'(N - 1));
  assign status.out_free   = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_char;
  assign m_tlast  = out_last;

endmodule

FILE: hw/rtl/pfc_ctrl.sv
module pfc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  pfc_pkg::status_t status,
  output pfc_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_FILL     = 3'd2;
  localparam logic [2:0] S_LOOK     = 3'd3;
  localparam logic [2:0] S_RD2      = 3'd4;
  localparam logic [2:0] S_RD3      = 3'd5;
  localparam logic [2:0] S_OUT1     = 3'd6;
  localparam logic [2:0] S_OUT2     = 3'd7;

  logic [2:0] state, state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch_item = 1'b1;
          state_next     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_IDLE;
        unique case (status.kind)
          pfc_pkg::KIND_KEY: begin
            cmd.key_place = 1'b1;
          end
          pfc_pkg::KIND_FINISH: begin
            if (!status.grid_ready) begin
              cmd.fill_start = 1'b1;
              state_next     = S_FILL;
            end
          end
          pfc_pkg::KIND_TEXT: begin
            if (status.grid_ready && status.sym_ok) begin
              state_next = S_LOOK;
            end
          end
          default: begin
            if (status.grid_ready && status.pend_valid) begin
              state_next = S_LOOK;
            end
          end
        endcase
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          state_next = S_IDLE;
        end
      end
      S_LOOK: begin
        if (status.kind == pfc_pkg::KIND_TEXT && !status.pend_valid) begin
          cmd.set_pending = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.save_cur = 1'b1;
          state_next   = S_RD2;
        end
      end
      S_RD2: begin
        cmd.sel_addr2 = 1'b1;
        cmd.cap1      = 1'b1;
        state_next    = S_RD3;
      end
      S_RD3: begin
        cmd.cap2   = 1'b1;
        state_next = S_OUT1;
      end
      S_OUT1: begin
        if (status.out_free) begin
          cmd.load_out1 = 1'b1;
          state_next    = S_OUT2;
        end
      end
      S_OUT2: begin
        if (status.out_free) begin
          cmd.load_out2     = 1'b1;
          cmd.clear_pending = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hw/rtl/pfc_checker.sv
module pfc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic [1:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // A waiting input transaction holds still until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
    else $error("input changed while waiting");

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // Every result is an upper case letter or a digit.
  a_out_alnum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata >= 8'd65 && m_tdata <= 8'd90) ||
                 (m_tdata >= 8'd48 && m_tdata <= 8'd57))
    else $error("output symbol outside the alphabet");

  // While the first symbol of a pair is shown, the second is still owed.
  a_pair_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken before the pair was finished");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind playfair_square_bigram_cipher pfc_checker u_pfc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
